// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers, included by euler_rotate_scale_translate.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must also hold while reset is applied
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/ersr_pkg.sv
// ----------------------------------------------------------------------------
// ersr_pkg
// Types, register indexes and tables for the Euler rotate-scale-translate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ersr_pkg;

  localparam int COEF_W    = 18;
  localparam int FIX_W     = 32;
  localparam int FIELD_W   = 16;
  localparam int CFG_W     = 48;
  localparam int IDX_W     = 3;
  localparam int NUM_COEF  = 9;
  localparam int NUM_OPS   = 15;
  localparam int MAX_STEPS = 24;
  localparam int CORD_W    = 34;
  localparam int TMP_W     = 20;
  localparam int ACC_W     = 25;

  localparam logic signed [CORD_W-1:0] CORD_GAIN = 34'sd652032874;
  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_MAX  = 18'sd131071;
  localparam logic signed [COEF_W-1:0] COEF_MIN  = -18'sd131072;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [FIX_W-1:0]  fix_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ANGLES   = 3'd0,
    REG_SCALE_X  = 3'd1,
    REG_SCALE_Y  = 3'd2,
    REG_SCALE_Z  = 3'd3,
    REG_OFFSET_X = 3'd4,
    REG_OFFSET_Y = 3'd5,
    REG_OFFSET_Z = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MATRIX
  } coef_state_t;

  typedef enum logic [3:0] {
    OPND_CH,
    OPND_SH,
    OPND_CP,
    OPND_SP,
    OPND_CB,
    OPND_SB,
    OPND_SHSP,
    OPND_CHSP,
    OPND_ONE
  } opnd_t;

  typedef enum logic [1:0] {
    DST_SHSP,
    DST_CHSP,
    DST_ACC,
    DST_COEF
  } dst_t;

  typedef struct packed {
    opnd_t      a;
    opnd_t      b;
    logic       neg;
    logic       add_acc;
    dst_t       dst;
    logic [3:0] idx;
  } mat_op_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] arc(input logic [4:0] i);
    case (i)
      5'd0:    arc = 32'h2000_0000;
      5'd1:    arc = 32'h12E4_051E;
      5'd2:    arc = 32'h09FB_385B;
      5'd3:    arc = 32'h0511_11D4;
      5'd4:    arc = 32'h028B_0D43;
      5'd5:    arc = 32'h0145_D7E1;
      5'd6:    arc = 32'h00A2_F61E;
      5'd7:    arc = 32'h0051_7C55;
      5'd8:    arc = 32'h0028_BE53;
      5'd9:    arc = 32'h0014_5F2F;
      5'd10:   arc = 32'h000A_2F98;
      5'd11:   arc = 32'h0005_17CC;
      5'd12:   arc = 32'h0002_8BE6;
      5'd13:   arc = 32'h0001_45F3;
      5'd14:   arc = 32'h0000_A2FA;
      5'd15:   arc = 32'h0000_517D;
      5'd16:   arc = 32'h0000_28BE;
      5'd17:   arc = 32'h0000_145F;
      5'd18:   arc = 32'h0000_0A30;
      5'd19:   arc = 32'h0000_0518;
      5'd20:   arc = 32'h0000_028C;
      5'd21:   arc = 32'h0000_0146;
      5'd22:   arc = 32'h0000_00A3;
      5'd23:   arc = 32'h0000_0051;
      default: arc = 32'h0000_0000;
    endcase
  endfunction

  // Matrix build program: one rounded product per step
  function automatic mat_op_t mat_op(input logic [3:0] n);
    case (n)
      4'd0:    mat_op = '{OPND_SH,   OPND_SP,  1'b0, 1'b0, DST_SHSP, 4'd0};
      4'd1:    mat_op = '{OPND_CH,   OPND_SP,  1'b0, 1'b0, DST_CHSP, 4'd0};
      4'd2:    mat_op = '{OPND_CH,   OPND_CB,  1'b0, 1'b0, DST_ACC,  4'd0};
      4'd3:    mat_op = '{OPND_SHSP, OPND_SB,  1'b0, 1'b1, DST_COEF, 4'd0};
      4'd4:    mat_op = '{OPND_SB,   OPND_CP,  1'b0, 1'b0, DST_COEF, 4'd1};
      4'd5:    mat_op = '{OPND_SH,   OPND_CB,  1'b1, 1'b0, DST_ACC,  4'd0};
      4'd6:    mat_op = '{OPND_CHSP, OPND_SB,  1'b0, 1'b1, DST_COEF, 4'd2};
      4'd7:    mat_op = '{OPND_CH,   OPND_SB,  1'b1, 1'b0, DST_ACC,  4'd0};
      4'd8:    mat_op = '{OPND_SHSP, OPND_CB,  1'b0, 1'b1, DST_COEF, 4'd3};
      4'd9:    mat_op = '{OPND_CB,   OPND_CP,  1'b0, 1'b0, DST_COEF, 4'd4};
      4'd10:   mat_op = '{OPND_SB,   OPND_SH,  1'b0, 1'b0, DST_ACC,  4'd0};
      4'd11:   mat_op = '{OPND_CHSP, OPND_CB,  1'b0, 1'b1, DST_COEF, 4'd5};
      4'd12:   mat_op = '{OPND_SH,   OPND_CP,  1'b0, 1'b0, DST_COEF, 4'd6};
      4'd13:   mat_op = '{OPND_SP,   OPND_ONE, 1'b1, 1'b0, DST_COEF, 4'd7};
      4'd14:   mat_op = '{OPND_CH,   OPND_CP,  1'b0, 1'b0, DST_COEF, 4'd8};
      default: mat_op = '{OPND_ONE,  OPND_ONE, 1'b0, 1'b0, DST_ACC,  4'd0};
    endcase
  endfunction

endpackage

// File: rtl/ersr_coef.sv
// ----------------------------------------------------------------------------
// ersr_coef
// Sequential CORDIC sine/cosine of three angles and matrix coefficient build.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ersr_coef
  import ersr_pkg::*;
#(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CFG_W-1:0]   start_angles,
  output logic               busy,
  output coef_t              coef [NUM_COEF]
);

  localparam int STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
  localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - ANGLE_BITS);

  coef_state_t                state_r, state_nxt;
  logic [1:0]                 ang_r, ang_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [3:0]                 op_r, op_nxt;
  logic [CFG_W-1:0]           angles_r;
  logic signed [CORD_W-1:0]   x_r, y_r;
  logic signed [31:0]         z_r;
  logic [1:0]                 q_r;
  coef_t                      trig_r [6];
  logic signed [TMP_W-1:0]    shsp_r, chsp_r;
  logic signed [ACC_W-1:0]    acc_r;
  coef_t                      coef_r [NUM_COEF];

  logic [CFG_W-1:0]           src_angles;
  logic [1:0]                 ld_ang;
  logic [FIELD_W-1:0]         field;
  logic [31:0]                phase, phase_q;
  logic [1:0]                 ld_q;
  logic signed [31:0]         ld_z;
  logic                       load;
  logic                       dir;
  logic signed [CORD_W-1:0]   sx, sy, nx, ny, c_raw, s_raw;
  logic signed [31:0]         arcv, nz;
  coef_t                      c_val, s_val;
  mat_op_t                    op;
  logic signed [TMP_W-1:0]    opa, opb;
  logic signed [2*TMP_W-1:0]  prod;
  logic signed [ACC_W-1:0]    term, sum;
  coef_t                      sum_sat;

  function automatic logic signed [TMP_W-1:0] pick(input opnd_t s,
                                                   input coef_t t [6],
                                                   input logic signed [TMP_W-1:0] a,
                                                   input logic signed [TMP_W-1:0] b);
    case (s)
      OPND_CH:   pick = TMP_W'(t[0]);
      OPND_SH:   pick = TMP_W'(t[1]);
      OPND_CP:   pick = TMP_W'(t[2]);
      OPND_SP:   pick = TMP_W'(t[3]);
      OPND_CB:   pick = TMP_W'(t[4]);
      OPND_SB:   pick = TMP_W'(t[5]);
      OPND_SHSP: pick = a;
      OPND_CHSP: pick = b;
      default:   pick = TMP_W'(COEF_ONE);
    endcase
  endfunction

  function automatic coef_t to_coef(input logic signed [CORD_W-1:0] v);
    logic signed [CORD_W:0]   r;
    logic signed [CORD_W-14:0] s;
    r = CORD_W'(v) + (CORD_W+1)'(8192);
    s = r[CORD_W:14];
    if (s > (CORD_W-13)'(COEF_MAX)) begin
      to_coef = COEF_MAX;
    end else if (s < (CORD_W-13)'(COEF_MIN)) begin
      to_coef = COEF_MIN;
    end else begin
      to_coef = s[COEF_W-1:0];
    end
  endfunction

  // CORDIC init for the next angle
  always_comb begin
    load       = (state_r == ST_IDLE) ? start : (state_r == ST_CORDIC && step_r == LAST_STEP
                 && ang_r != 2'd2);
    src_angles = (state_r == ST_IDLE) ? start_angles : angles_r;
    ld_ang     = (state_r == ST_IDLE) ? 2'd0 : ang_r + 2'd1;
    case (ld_ang)
      2'd0:    field = src_angles[47:32];
      2'd1:    field = src_angles[31:16];
      default: field = src_angles[15:0];
    endcase
    phase   = {field, 16'h0000} & PHASE_MASK;
    phase_q = phase + 32'h2000_0000;
    ld_q    = phase_q[31:30];
    ld_z    = $signed(phase - {ld_q, 30'h0});
  end

  // one CORDIC micro-rotation and quadrant restore
  always_comb begin
    dir  = !z_r[31];
    sx   = x_r >>> step_r;
    sy   = y_r >>> step_r;
    arcv = $signed(arc(5'(step_r)));
    nx   = dir ? x_r - sy : x_r + sy;
    ny   = dir ? y_r + sx : y_r - sx;
    nz   = dir ? z_r - arcv : z_r + arcv;
    case (q_r)
      2'd0:    begin c_raw = nx;  s_raw = ny;  end
      2'd1:    begin c_raw = -ny; s_raw = nx;  end
      2'd2:    begin c_raw = -nx; s_raw = -ny; end
      default: begin c_raw = ny;  s_raw = -nx; end
    endcase
    c_val = to_coef(c_raw);
    s_val = to_coef(s_raw);
  end

  // shared rounded multiply for the matrix program
  always_comb begin
    op   = mat_op(op_r);
    opa  = pick(op.a, trig_r, shsp_r, chsp_r);
    opb  = pick(op.b, trig_r, shsp_r, chsp_r);
    prod = opa * opb;
    term = ACC_W'((prod + (2*TMP_W)'(32768)) >>> 16);
    if (op.neg) begin
      term = -term;
    end
    sum = op.add_acc ? acc_r + term : term;
    if (sum > ACC_W'(COEF_MAX)) begin
      sum_sat = COEF_MAX;
    end else if (sum < ACC_W'(COEF_MIN)) begin
      sum_sat = COEF_MIN;
    end else begin
      sum_sat = sum[COEF_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    ang_nxt   = ang_r;
    step_nxt  = step_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CORDIC;
          ang_nxt   = 2'd0;
          step_nxt  = '0;
        end
      end
      ST_CORDIC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          step_nxt = '0;
          ang_nxt  = ang_r + 2'd1;
          if (ang_r == 2'd2) begin
            state_nxt = ST_MATRIX;
            op_nxt    = '0;
          end
        end
      end
      ST_MATRIX: begin
        op_nxt = op_r + 4'd1;
        if (op_r == 4'(NUM_OPS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ang_r   <= 2'd0;
      step_r  <= '0;
      op_r    <= '0;
      for (int i = 0; i < NUM_COEF; i++) begin
        coef_r[i] <= (i % 4 == 0) ? COEF_ONE : '0;
      end
    end else begin
      state_r <= state_nxt;
      ang_r   <= ang_nxt;
      step_r  <= step_nxt;
      op_r    <= op_nxt;
      if (state_r == ST_MATRIX && op.dst == DST_COEF) begin
        coef_r[op.idx] <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      angles_r <= start_angles;
    end
    if (load) begin
      x_r <= CORD_GAIN;
      y_r <= '0;
      z_r <= ld_z;
      q_r <= ld_q;
    end else if (state_r == ST_CORDIC) begin
      x_r <= nx;
      y_r <= ny;
      z_r <= nz;
    end
    if (state_r == ST_CORDIC && step_r == LAST_STEP) begin
      trig_r[{ang_r, 1'b0}] <= c_val;
      trig_r[{ang_r, 1'b1}] <= s_val;
    end
    if (state_r == ST_MATRIX) begin
      case (op.dst)
        DST_SHSP: shsp_r <= TMP_W'(sum);
        DST_CHSP: chsp_r <= TMP_W'(sum);
        DST_ACC:  acc_r  <= sum;
        default:  acc_r  <= acc_r;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign coef = coef_r;

endmodule

// File: rtl/euler_rotate_scale_translate.sv
// ----------------------------------------------------------------------------
// euler_rotate_scale_translate
// Rotates each point by a yaw-pitch-roll matrix, scales per axis and offsets.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | in_x, in_y, in_z, in_last
//  out     | out       | out_valid/out_stall| out_x, out_y, out_z, out_last
//
//  One point per cycle while nothing stalls, through four register stages.
//  A write of the angle register runs the shared CORDIC and multiplier, with
//  in_stall high while they run.
//  Reset is synchronous and restores the identity matrix, unit scale, zero offset.
//  Each stage holds under out_stall only while the stage after it is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module euler_rotate_scale_translate
  import ersr_pkg::*;
#(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  fix_t             in_x,
  input  fix_t             in_y,
  input  fix_t             in_z,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output fix_t             out_x,
  output fix_t             out_y,
  output fix_t             out_z,
  output logic             out_last
);

  localparam int PROD_W  = COEF_W + FIX_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int SPROD_W = 2 * FIX_W;

  fix_t                       scale_r  [3];
  fix_t                       offset_r [3];
  coef_t                      coef     [NUM_COEF];
  logic                       coef_busy;
  logic                       coef_start;

  logic                       v1_r, v2_r, v3_r, v4_r;
  logic                       en1, en2, en3, en4;
  logic signed [PROD_W-1:0]   prod_r  [NUM_COEF];
  logic signed [PROD_W-1:0]   prod_nxt[NUM_COEF];
  fix_t                       rot_r   [3];
  fix_t                       rot_nxt [3];
  logic signed [SPROD_W-1:0]  sprod_r [3];
  logic signed [SPROD_W-1:0]  sprod_nxt[3];
  fix_t                       res_r   [3];
  fix_t                       res_nxt [3];
  logic                       last1_r, last2_r, last3_r, last4_r;
  fix_t                       pt [3];
  logic signed [SUM_W-1:0]    acc;
  logic signed [SUM_W-17:0]   acc_sh;
  logic signed [SPROD_W-16:0] fin;

  assign coef_start = cfg_we && (reg_idx_t'(cfg_index) == REG_ANGLES);

  ersr_coef #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_coef (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (coef_start),
    .start_angles (cfg_data),
    .busy         (coef_busy),
    .coef         (coef)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        scale_r[i]  <= 32'sd65536;
        offset_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SCALE_X:  scale_r[0]  <= cfg_data[FIX_W-1:0];
        REG_SCALE_Y:  scale_r[1]  <= cfg_data[FIX_W-1:0];
        REG_SCALE_Z:  scale_r[2]  <= cfg_data[FIX_W-1:0];
        REG_OFFSET_X: offset_r[0] <= cfg_data[FIX_W-1:0];
        REG_OFFSET_Y: offset_r[1] <= cfg_data[FIX_W-1:0];
        REG_OFFSET_Z: offset_r[2] <= cfg_data[FIX_W-1:0];
        default:      scale_r[0]  <= scale_r[0];
      endcase
    end
  end

  // advance a stage when it is empty or its successor moves
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1 || coef_busy;

  always_comb begin
    pt[0] = in_x;
    pt[1] = in_y;
    pt[2] = in_z;
    for (int k = 0; k < NUM_COEF; k++) begin
      prod_nxt[k] = coef[k] * pt[k % 3];
    end
    for (int k = 0; k < 3; k++) begin
      acc = SUM_W'(prod_r[3*k]) + SUM_W'(prod_r[3*k+1]) + SUM_W'(prod_r[3*k+2])
            + SUM_W'(32768);
      acc_sh = acc[SUM_W-1:16];
      if (acc_sh > (SUM_W-16)'(32'sh7FFF_FFFF)) begin
        rot_nxt[k] = 32'sh7FFF_FFFF;
      end else if (acc_sh < (SUM_W-16)'(-33'sh8000_0000)) begin
        rot_nxt[k] = -32'sh8000_0000;
      end else begin
        rot_nxt[k] = acc_sh[FIX_W-1:0];
      end
      sprod_nxt[k] = rot_r[k] * scale_r[k];
      fin = (SPROD_W-15)'((sprod_r[k] + SPROD_W'(32768)) >>> 16)
            + (SPROD_W-15)'(offset_r[k]);
      if (fin > (SPROD_W-15)'(32'sh7FFF_FFFF)) begin
        res_nxt[k] = 32'sh7FFF_FFFF;
      end else if (fin < (SPROD_W-15)'(-33'sh8000_0000)) begin
        res_nxt[k] = -32'sh8000_0000;
      end else begin
        res_nxt[k] = fin[FIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid && !in_stall;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      prod_r  <= prod_nxt;
      last1_r <= in_last;
    end
    if (en2) begin
      rot_r   <= rot_nxt;
      last2_r <= last1_r;
    end
    if (en3) begin
      sprod_r <= sprod_nxt;
      last3_r <= last2_r;
    end
    if (en4) begin
      res_r   <= res_nxt;
      last4_r <= last3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_x     = res_r[0];
  assign out_y     = res_r[1];
  assign out_z     = res_r[2];
  assign out_last  = last4_r;

  `ASSERT_CLK(a_busy_stalls, coef_busy |-> in_stall, "input accepted during matrix build")
  `ASSERT_CLK(a_angle_starts, coef_start && !coef_busy |=> coef_busy, "angle write did not start build")
  `ASSERT_CLK(a_stage_hold, v1_r && !en2 |=> v1_r, "stage one transaction dropped")

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams points through the Euler rotate-scale-translate block under several
// configurations and idle patterns, and checks every output transaction
// against a bit-exact predictor of the rotation, scaling and translation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import ersr_pkg::*;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    logic last;
  } point_t;

  localparam int WATCHDOG = 20000;
  localparam int TAIL     = 20;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  fix_t             in_x = '0, in_y = '0, in_z = '0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  fix_t             out_x, out_y, out_z;
  logic             out_last;

  euler_rotate_scale_translate dut (.*);

  initial forever #4 clk = ~clk;

  // predictor state
  longint coef[9];
  longint scl[3];
  longint ofs[3];

  point_t pending_points[$];
  point_t expected_points[$];
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_cycles = 0;
  bit     failed = 0;
  int     quiet_cycles = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint mulq(longint a, longint b);
    return asr(a * b + 32768, 16);
  endfunction

  function automatic void cordic_sincos(logic [15:0] ang, output longint c, output longint s);
    logic [31:0] phase;
    logic [1:0]  q;
    longint z, x, y, nx, cc, ss;
    phase = {ang, 16'h0};
    q = 2'((phase + 32'h2000_0000) >> 30);
    z = longint'(phase) - longint'(q) * 64'h4000_0000;
    if (z >= 64'sh8000_0000) z -= 64'sh1_0000_0000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        z -= longint'(arc(5'(i)));
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        z += longint'(arc(5'(i)));
      end
      x = nx;
    end
    case (q)
      2'd0: begin cc = x; ss = y; end
      2'd1: begin cc = -y; ss = x; end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = clip(asr(cc + 8192, 14), -131072, 131071);
    s = clip(asr(ss + 8192, 14), -131072, 131071);
  endfunction

  function automatic void load_rotation(logic [47:0] angles);
    longint ch, sh, cp, sp, cb, sb, shsp, chsp;
    cordic_sincos(angles[47:32], ch, sh);
    cordic_sincos(angles[31:16], cp, sp);
    cordic_sincos(angles[15:0], cb, sb);
    shsp = mulq(sh, sp);
    chsp = mulq(ch, sp);
    coef[0] = clip(mulq(ch, cb) + mulq(shsp, sb), -131072, 131071);
    coef[1] = clip(mulq(sb, cp), -131072, 131071);
    coef[2] = clip(-mulq(sh, cb) + mulq(chsp, sb), -131072, 131071);
    coef[3] = clip(-mulq(ch, sb) + mulq(shsp, cb), -131072, 131071);
    coef[4] = clip(mulq(cb, cp), -131072, 131071);
    coef[5] = clip(mulq(sb, sh) + mulq(chsp, cb), -131072, 131071);
    coef[6] = clip(mulq(sh, cp), -131072, 131071);
    coef[7] = clip(-sp, -131072, 131071);
    coef[8] = clip(mulq(ch, cp), -131072, 131071);
  endfunction

  function automatic point_t transform_point(point_t p);
    longint v[3], r, t;
    point_t o;
    fix_t res[3];
    v[0] = p.x; v[1] = p.y; v[2] = p.z;
    for (int k = 0; k < 3; k++) begin
      r = asr(coef[3*k] * v[0] + coef[3*k+1] * v[1] + coef[3*k+2] * v[2] + 32768, 16);
      r = clip(r, -64'sd2147483648, 64'sd2147483647);
      t = clip(asr(r * scl[k] + 32768, 16) + ofs[k], -64'sd2147483648, 64'sd2147483647);
      res[k] = fix_t'(t);
    end
    o.x = res[0]; o.y = res[1]; o.z = res[2]; o.last = p.last;
    return o;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [47:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ANGLES:   load_rotation(val);
      REG_SCALE_X:  scl[0] = longint'(fix_t'(val[31:0]));
      REG_SCALE_Y:  scl[1] = longint'(fix_t'(val[31:0]));
      REG_SCALE_Z:  scl[2] = longint'(fix_t'(val[31:0]));
      REG_OFFSET_X: ofs[0] = longint'(fix_t'(val[31:0]));
      REG_OFFSET_Y: ofs[1] = longint'(fix_t'(val[31:0]));
      default:      ofs[2] = longint'(fix_t'(val[31:0]));
    endcase
    @(posedge clk);
    // hold until the matrix build has finished
    if (idx == REG_ANGLES) begin
      while (in_stall) @(posedge clk);
    end
  endtask

  function automatic fix_t rand_fix();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return fix_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return fix_t'($urandom);
    endcase
  endfunction

  task automatic queue_point(fix_t x, fix_t y, fix_t z, logic last);
    point_t p;
    p = '{x, y, z, last};
    pending_points.push_back(p);
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          point_t p;
          p = pending_points.pop_front();
          expected_points.push_back(transform_point(p));
          in_valid <= 1'b1;
          in_x <= p.x; in_y <= p.y; in_z <= p.z; in_last <= p.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected transaction x=%0d y=%0d z=%0d", out_x, out_y, out_z);
        failed = 1;
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (out_x !== e.x) begin $error("out_x exp %0d got %0d", e.x, out_x); failed = 1; end
        if (out_y !== e.y) begin $error("out_y exp %0d got %0d", e.y, out_y); failed = 1; end
        if (out_z !== e.z) begin $error("out_z exp %0d got %0d", e.z, out_z); failed = 1; end
        if (out_last !== e.last) begin
          $error("out_last exp %0b got %0b", e.last, out_last);
          failed = 1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
      quiet_cycles <= 0;
    else if (pending_points.size() != 0 || expected_points.size() != 0 || in_valid) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [47:0] angle_sets[6];
    int idle_sets[4][2];
    for (int i = 0; i < 9; i++) coef[i] = (i % 4 == 0) ? 65536 : 0;
    for (int k = 0; k < 3; k++) begin scl[k] = 65536; ofs[k] = 0; end
    idle_sets = '{'{0, 0}, '{61, 0}, '{0, 61}, '{24, 24}};
    angle_sets = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h4000_8000_C000,
                   48'h2000_1000_E000, 48'h0, 48'h0};
    angle_sets[4] = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    angle_sets[5] = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity after reset, field extremes
    queue_point(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1'b0);
    queue_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b1);
    queue_point(32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF, 1'b0);
    queue_point(0, 0, 0, 1'b1);
    drain();

    // zero angles via CORDIC, saturated rotation, extreme scale and offset
    write_reg(REG_ANGLES, 48'h0);
    write_reg(REG_ANGLES, 48'h2000_2000_2000);
    write_reg(REG_SCALE_X, 48'h7FFF_FFFF);
    write_reg(REG_SCALE_Y, 48'h8000_0000);
    write_reg(REG_SCALE_Z, 48'h0);
    write_reg(REG_OFFSET_X, 48'h7FFF_FFFF);
    write_reg(REG_OFFSET_Y, 48'h8000_0000);
    write_reg(REG_OFFSET_Z, 48'hFFFF_FFFF);
    queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    queue_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    queue_point(32'sh0000_8000, 32'shFFFF_8000, 32'sh0000_0001, 1'b1);
    queue_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_ANGLES, angle_sets[ph]);
      write_reg(REG_SCALE_X, ph == 5 ? 48'h8000_0000 : 48'(rand_fix()));
      write_reg(REG_SCALE_Y, ph == 3 ? 48'h7FFF_FFFF : 48'(rand_fix()));
      write_reg(REG_SCALE_Z, 48'($urandom_range(0, 32'h0004_0000)));
      write_reg(REG_OFFSET_X, 48'(rand_fix()));
      write_reg(REG_OFFSET_Y, 48'(rand_fix()));
      write_reg(REG_OFFSET_Z, 48'(rand_fix()));
      for (int ip = 0; ip < 4; ip++) begin
        send_idle_pct  = idle_sets[ip][0];
        recv_stall_pct = idle_sets[ip][1];
        if (ph == 1 && ip == 0) hold_cycles = 300;
        for (int n = 0; n < 50; n++)
          queue_point(rand_fix(), rand_fix(), rand_fix(), 1'($urandom));
        drain();
      end
    end

    if (!failed)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/ersr_pkg.sv
rtl/ersr_coef.sv
rtl/euler_rotate_scale_translate.sv
bench/tb_top.sv
